// ===== hw/rtl/skvt_pkg.sv =====
// skvt_pkg: shared constants, command/status codes, sequencer states and the
// memory request bundle for the sorted key/value table. No dependencies.

package skvt_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 7;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Register index is the word address, paddr[CFG_AW-1:2].
  localparam logic REG_ORDER = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FOUND    = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_RESPOND
  } seq_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              key_we;
    logic              val_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_key;
    logic [DATA_W-1:0] wr_val;
  } mem_req_t;

  // Non-strict order: a may stand at or before b.
  function automatic logic comes_first(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b,
                                       input logic desc);
    logic res;
    res = desc ? (a >= b) : (a <= b);
    return res;
  endfunction

endpackage

// ===== hw/rtl/sorted_key_value_table_top.sv =====
// sorted_key_value_table_top: sorted key/value table, top level.
// Depends on skvt_pkg, skvt_cfg, skvt_seq and skvt_ram.
//
//  Channel   Handshake                         Ports
//  --------  --------------------------------  --------------------------------
//  request   start & !busy accepts             in_command, in_key, in_new_value
//  result    out_valid, one cycle, no stall    out_status, out_value_out,
//                                              out_entry_count
//  config    APB write: psel&penable&pwrite    paddr, pwdata, prdata, pready
//
//  Steps from acceptance to result, N = entries held, p = entry the walk stops at:
//    walk over entries 0..p (all N on a miss), decide, then for an insert shift N-p
//    entries, drain and place (an append places at once), for a remove shift N-p-1
//    entries and drain (neither for the last entry), then the result; an empty table
//    or an unused command skips the walk. Entries move one at a time, as the memories
//    have a single read and a single write port.
//  Reset (rst_n low, synchronous) empties the table and selects ascending
//  order; the memories themselves are not cleared.
//  Results cannot be stalled: out_valid is high for exactly one cycle.
//  busy goes high once a request is accepted and stays high through the result.
//
// Keys and values sit in two RAMs addressed by position, sorted by key.
// One compare unit checks each stored key as it comes out of the RAM.
// Insert/remove then moves entries one per cycle to open or close a gap.

module sorted_key_value_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [skvt_pkg::CMD_W-1:0]    in_command,
  input  logic [skvt_pkg::DATA_W-1:0]   in_key,
  input  logic [skvt_pkg::DATA_W-1:0]   in_new_value,
  // result
  output logic                          out_valid,
  output logic [skvt_pkg::STATUS_W-1:0] out_status,
  output logic [skvt_pkg::DATA_W-1:0]   out_value_out,
  output logic [skvt_pkg::ENTRY_W-1:0]  out_entry_count,
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skvt_pkg::CFG_AW-1:0]   paddr,
  input  logic [skvt_pkg::CFG_DW-1:0]   pwdata,
  output logic [skvt_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import skvt_pkg::*;

  logic              order_desc;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_val;

  skvt_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .order_desc (order_desc)
  );

  skvt_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_new_value    (in_new_value),
    .order_desc      (order_desc),
    .rd_key          (rd_key),
    .rd_val          (rd_val),
    .mem_req         (mem_req),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

  // key store
  skvt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk     (clk),
    .we      (mem_req.key_we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_key),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_key)
  );

  // value store, same addressing; a replace writes only this one
  skvt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk     (clk),
    .we      (mem_req.val_we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_val),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_val)
  );

endmodule

// ===== hw/rtl/skvt_ram.sv =====
// skvt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module skvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/skvt_cfg.sv =====
// skvt_cfg: APB-style register file holding the key order select.
// Depends on skvt_pkg.

module skvt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skvt_pkg::CFG_AW-1:0] paddr,
  input  logic [skvt_pkg::CFG_DW-1:0] pwdata,
  output logic [skvt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic                        order_desc
);
  import skvt_pkg::*;

  logic order_r;
  logic order_nxt;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_ORDER);

  always_comb begin
    order_nxt = order_r;
    if (wr_hit) begin
      order_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else begin
      order_r <= order_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1:2] == REG_ORDER) begin
      prdata = {{(CFG_DW-1){1'b0}}, order_r};
    end
  end

  assign order_desc = order_r;

endmodule

// ===== hw/rtl/skvt_seq.sv =====
// skvt_seq: sequencer and shared compare unit; walks, shifts and updates the
// key/value memories one entry per cycle. Depends on skvt_pkg.

module skvt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [skvt_pkg::CMD_W-1:0]    in_command,
  input  logic [skvt_pkg::DATA_W-1:0]   in_key,
  input  logic [skvt_pkg::DATA_W-1:0]   in_new_value,
  input  logic                          order_desc,
  input  logic [skvt_pkg::DATA_W-1:0]   rd_key,
  input  logic [skvt_pkg::DATA_W-1:0]   rd_val,
  output skvt_pkg::mem_req_t            mem_req,
  output logic                          busy,
  output logic                          out_valid,
  output logic [skvt_pkg::STATUS_W-1:0] out_status,
  output logic [skvt_pkg::DATA_W-1:0]   out_value_out,
  output logic [skvt_pkg::ENTRY_W-1:0]  out_entry_count
);
  import skvt_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] nval_r, nval_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]  slot_r, slot_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] old_r, old_nxt;
  logic              mv_vld_r, mv_vld_nxt;
  logic [IDX_W-1:0]  mv_dst_r, mv_dst_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] vout_r, vout_nxt;

  logic              eq_here;
  logic              cf_here;
  logic              stop_here;
  logic [CNT_W-1:0]  count_m1;
  logic              cmd_ok;

  // Shared compare unit: one stored key against the request key.
  assign eq_here   = (rd_key == key_r);
  assign cf_here   = comes_first(key_r, rd_key, order_desc);
  assign stop_here = (cmd_r == CMD_SEARCH) ? eq_here : cf_here;
  assign count_m1  = count_r - CNT_W'(1);
  assign cmd_ok    = (in_command == CMD_ADD) || (in_command == CMD_SEARCH) ||
                     (in_command == CMD_REMOVE);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    nval_nxt    = nval_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    src_nxt     = src_r;
    hit_nxt     = hit_r;
    old_nxt     = old_r;
    mv_vld_nxt  = mv_vld_r;
    mv_dst_nxt  = mv_dst_r;
    status_nxt  = status_r;
    vout_nxt    = vout_r;
    out_valid   = 1'b0;

    mem_req         = '0;
    mem_req.wr_addr = slot_r[IDX_W-1:0];
    mem_req.wr_key  = key_r;
    mem_req.wr_val  = nval_r;

    case (state_r)
      S_IDLE: begin
        mem_req.rd_addr = '0;
        if (start) begin
          cmd_nxt  = in_command;
          key_nxt  = in_key;
          nval_nxt = in_new_value;
          if ((count_r == '0) || !cmd_ok) begin
            slot_nxt  = '0;
            hit_nxt   = 1'b0;
            old_nxt   = '0;
            state_nxt = S_DECIDE;
          end else begin
            // entry 0 read is already on its way
            rd_idx_nxt  = CNT_W'(1);
            cmp_idx_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        mem_req.rd_addr = rd_idx_r[IDX_W-1:0];
        if (stop_here) begin
          slot_nxt  = cmp_idx_r;
          hit_nxt   = eq_here;
          old_nxt   = rd_val;
          state_nxt = S_DECIDE;
        end else if (cmp_idx_r == count_m1) begin
          slot_nxt  = count_r;
          hit_nxt   = 1'b0;
          old_nxt   = '0;
          state_nxt = S_DECIDE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + CNT_W'(1);
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end
      end

      S_DECIDE: begin
        mv_vld_nxt = 1'b0;
        vout_nxt   = '0;
        status_nxt = ST_ABSENT;
        state_nxt  = S_RESPOND;
        case (cmd_r)
          CMD_ADD: begin
            if (hit_r) begin
              mem_req.val_we = 1'b1;
              status_nxt     = ST_REPLACED;
              vout_nxt       = old_r;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_INSERTED;
              if (slot_r == count_r) begin
                state_nxt = S_PLACE;
              end else begin
                src_nxt   = count_m1[IDX_W-1:0];
                state_nxt = S_SHIFT;
              end
            end
          end
          CMD_SEARCH: begin
            if (hit_r) begin
              status_nxt = ST_FOUND;
              vout_nxt   = old_r;
            end
          end
          CMD_REMOVE: begin
            if (hit_r) begin
              status_nxt = ST_REMOVED;
              vout_nxt   = old_r;
              if (slot_r == count_m1) begin
                count_nxt = count_m1;
              end else begin
                src_nxt   = slot_r[IDX_W-1:0] + IDX_W'(1);
                state_nxt = S_SHIFT;
              end
            end
          end
          default: begin
            status_nxt = ST_ABSENT;
          end
        endcase
      end

      S_SHIFT: begin
        mem_req.rd_addr = src_r;
        mv_vld_nxt      = 1'b1;
        if (cmd_r == CMD_ADD) begin
          // open a gap: move entries up, highest first
          mv_dst_nxt = src_r + IDX_W'(1);
          if (src_r == slot_r[IDX_W-1:0]) begin
            state_nxt = S_DRAIN;
          end else begin
            src_nxt = src_r - IDX_W'(1);
          end
        end else begin
          // close the gap: move entries down, lowest first
          mv_dst_nxt = src_r - IDX_W'(1);
          if (src_r == count_m1[IDX_W-1:0]) begin
            state_nxt = S_DRAIN;
          end else begin
            src_nxt = src_r + IDX_W'(1);
          end
        end
      end

      S_DRAIN: begin
        mv_vld_nxt = 1'b0;
        if (cmd_r == CMD_ADD) begin
          state_nxt = S_PLACE;
        end else begin
          count_nxt = count_m1;
          state_nxt = S_RESPOND;
        end
      end

      S_PLACE: begin
        mem_req.key_we = 1'b1;
        mem_req.val_we = 1'b1;
        count_nxt      = count_r + CNT_W'(1);
        state_nxt      = S_RESPOND;
      end

      S_RESPOND: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // pending move from the previous read takes the write port
    if (mv_vld_r) begin
      mem_req.key_we  = 1'b1;
      mem_req.val_we  = 1'b1;
      mem_req.wr_addr = mv_dst_r;
      mem_req.wr_key  = rd_key;
      mem_req.wr_val  = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      mv_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      mv_vld_r <= mv_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    nval_r    <= nval_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    src_r     <= src_nxt;
    hit_r     <= hit_nxt;
    old_r     <= old_nxt;
    mv_dst_r  <= mv_dst_nxt;
    status_r  <= status_nxt;
    vout_r    <= vout_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_status      = status_r;
  assign out_value_out   = vout_r;
  assign out_entry_count = ENTRY_W'(count_r);

endmodule

// ===== hw/rtl/skvt_checker.sv =====
// skvt_checker: port-level assertions for the sorted key/value table, bound
// to sorted_key_value_table_top. Depends on skvt_pkg.

module skvt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [skvt_pkg::STATUS_W-1:0] out_status,
  input logic [skvt_pkg::DATA_W-1:0]   out_value_out
);
  import skvt_pkg::*;

  // an accepted request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result only comes out of a request in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // after a result the block is idle and no second result follows
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block not idle after result");

  // value is zero on inserted, absent and full
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == ST_INSERTED) || (out_status == ST_ABSENT) ||
                   (out_status == ST_FULL))) |-> (out_value_out == '0))
    else $error("nonzero value with empty-value status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FULL))
    else $error("undefined status code");

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_value_out (out_value_out)
);
